// ===== src/sap_pkg.sv =====
// ----------------------------------------------------------------------------
// sap_pkg - shared types and constants of the stride address predictor
// Table geometry, field widths, request and register codes, entry layout.
// ----------------------------------------------------------------------------
package sap_pkg;

    // Number of table entries; a power of two, so the slot is the low pc bits
    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    localparam int ADDR_W    = 64;
    localparam int CONF_W    = 4;
    localparam int SIZE_W    = 8;
    localparam int AHEAD_W   = 8;
    localparam int CFG_IDX_W = 3;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CONF_W-1:0] conf_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [SIZE_W-1:0] size_t;

    // Request codes
    localparam logic REQ_PREDICT = 1'b0;
    localparam logic REQ_UPDATE  = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD  = 3'd0,
        CFG_UP_STEP    = 3'd1,
        CFG_DOWN_STEP  = 3'd2,
        CFG_SATURATION = 3'd3,
        CFG_INIT_CONF  = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        conf_t threshold;
        conf_t up_step;
        conf_t down_step;
        conf_t saturation;
        conf_t init_conf;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        threshold:  4'd2,
        up_step:    4'd1,
        down_step:  4'd1,
        saturation: 4'd3,
        init_conf:  4'd1
    };

    // Payload of one table entry (valid bits live in flops beside it)
    typedef struct packed {
        addr_t tag;
        addr_t last_addr;
        addr_t stride;
        conf_t conf;
        size_t size;
    } entry_t;

    function automatic idx_t slot_of(input addr_t pc_val);
        slot_of = idx_t'(pc_val % TABLE_ENTRIES);
    endfunction

endpackage

// ===== src/sap_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// sap_cfg_regs - configuration register file
// Five 4-bit registers; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module sap_cfg_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [sap_pkg::CFG_IDX_W-1:0] wr_index,
    input  sap_pkg::conf_t               wr_data,
    output sap_pkg::cfg_t                cfg
);
    import sap_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                CFG_THRESHOLD:  cfg_next.threshold  = wr_data;
                CFG_UP_STEP:    cfg_next.up_step    = wr_data;
                CFG_DOWN_STEP:  cfg_next.down_step  = wr_data;
                CFG_SATURATION: cfg_next.saturation = wr_data;
                CFG_INIT_CONF:  cfg_next.init_conf  = wr_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/sap_table.sv =====
// ----------------------------------------------------------------------------
// sap_table - predictor entry store
// Entry payload in a memory with registered read, valid bits in flops,
// and a bypass for a write landing on the edge the same slot is read.
// ----------------------------------------------------------------------------
module sap_table (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            rd_en,
    input  sap_pkg::idx_t   rd_idx,
    input  sap_pkg::idx_t   look_idx,
    input  logic            wr_en,
    input  sap_pkg::idx_t   wr_idx,
    input  sap_pkg::entry_t wr_entry,
    input  logic            wr_stride_valid,
    output logic            entry_valid,
    output logic            stride_valid,
    output sap_pkg::entry_t entry
);
    import sap_pkg::*;

    entry_t                   mem [TABLE_ENTRIES];
    entry_t                   rd_data_reg;
    entry_t                   fwd_entry_reg;
    logic                     fwd_hit_reg;
    logic [TABLE_ENTRIES-1:0] entry_valid_reg;
    logic [TABLE_ENTRIES-1:0] stride_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg   <= mem[rd_idx];
            fwd_entry_reg <= wr_entry;
        end
    end

    // read-before-write memory: catch the write of this same edge
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_hit_reg <= wr_en && (wr_idx == rd_idx);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg  <= '0;
            stride_valid_reg <= '0;
        end
        else if (wr_en)
        begin
            entry_valid_reg[wr_idx]  <= 1'b1;
            stride_valid_reg[wr_idx] <= wr_stride_valid;
        end
    end

    assign entry_valid  = entry_valid_reg[look_idx];
    assign stride_valid = stride_valid_reg[look_idx];
    assign entry        = fwd_hit_reg ? fwd_entry_reg : rd_data_reg;

endmodule

// ===== src/sap_learn.sv =====
// ----------------------------------------------------------------------------
// sap_learn - update rule for one entry
// Allocates on empty or tag mismatch, otherwise trains stride and confidence.
// ----------------------------------------------------------------------------
module sap_learn (
    input  logic            entry_valid,
    input  logic            stride_valid,
    input  sap_pkg::entry_t cur,
    input  sap_pkg::addr_t  pc,
    input  sap_pkg::addr_t  real_addr,
    input  sap_pkg::size_t  access_size,
    input  sap_pkg::cfg_t   cfg,
    output sap_pkg::entry_t nxt,
    output logic            nxt_stride_valid
);
    import sap_pkg::*;

    addr_t         guess;
    logic [CONF_W:0] up_sum;
    conf_t         conf_trained;

    assign guess  = cur.last_addr + cur.stride;
    assign up_sum = {1'b0, cur.conf} + {1'b0, cfg.up_step};

    always_comb
    begin
        priority if (guess == '0)
        begin
            conf_trained = cur.conf;
        end
        else if (guess == real_addr)
        begin
            // clamp also pulls an over-saturated count down
            conf_trained = (up_sum > {1'b0, cfg.saturation}) ?
                           cfg.saturation : up_sum[CONF_W-1:0];
        end
        else
        begin
            conf_trained = (cfg.down_step > cur.conf) ?
                           '0 : conf_t'(cur.conf - cfg.down_step);
        end
    end

    always_comb
    begin
        if (!entry_valid || (cur.tag != pc))
        begin
            nxt.tag          = pc;
            nxt.last_addr    = real_addr;
            nxt.stride       = '0;
            nxt.conf         = cfg.init_conf;
            nxt.size         = access_size;
            nxt_stride_valid = 1'b0;
        end
        else
        begin
            nxt.tag          = cur.tag;
            nxt.last_addr    = real_addr;
            nxt.stride       = real_addr - cur.last_addr;
            nxt.conf         = stride_valid ? conf_trained : cur.conf;
            nxt.size         = cur.size;
            nxt_stride_valid = 1'b1;
        end
    end

endmodule

// ===== src/sap_predict.sv =====
// ----------------------------------------------------------------------------
// sap_predict - prediction datapath and result register
// Stride times run-ahead into a product stage, then the add into the output.
// ----------------------------------------------------------------------------
module sap_predict (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  logic                       entry_valid,
    input  logic                       stride_valid,
    input  sap_pkg::entry_t            entry,
    input  logic [sap_pkg::AHEAD_W-1:0] run_ahead,
    input  sap_pkg::conf_t             threshold,
    output logic                       out_valid,
    input  logic                       out_stall,
    output sap_pkg::addr_t             predicted_addr,
    output sap_pkg::size_t             packet_size_out,
    output logic                       prediction_made
);
    import sap_pkg::*;

    addr_t stride_eff;
    addr_t product;
    logic  made;
    logic  out_take;

    logic  mul_valid_reg;
    addr_t mul_prod_reg;
    addr_t mul_last_reg;
    logic  mul_made_reg;
    size_t mul_size_reg;

    logic  out_valid_reg;
    addr_t out_addr_reg;
    size_t out_size_reg;
    logic  out_made_reg;

    assign stride_eff = stride_valid ? entry.stride : '0;
    assign product    = stride_eff * ADDR_W'(run_ahead);
    assign made       = entry_valid && (entry.conf >= threshold);

    assign out_take  = !out_valid_reg || !out_stall;
    assign req_ready = !mul_valid_reg || out_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_ready)
            begin
                mul_valid_reg <= req_valid;
            end
            if (out_take)
            begin
                out_valid_reg <= mul_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
        begin
            mul_prod_reg <= product;
            mul_last_reg <= entry.last_addr;
            mul_made_reg <= made;
            mul_size_reg <= entry_valid ? entry.size : '0;
        end
        if (out_take && mul_valid_reg)
        begin
            out_addr_reg <= mul_made_reg ? (mul_last_reg + mul_prod_reg) : '0;
            out_size_reg <= mul_size_reg;
            out_made_reg <= mul_made_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign predicted_addr  = out_addr_reg;
    assign packet_size_out = out_size_reg;
    assign prediction_made = out_made_reg;

endmodule

// ===== src/stride_address_predictor.sv =====
// ----------------------------------------------------------------------------
// stride_address_predictor - pc-indexed stride address predictor
// Direct-mapped table that learns per-load strides and predicts addresses.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one request beat per cycle while in_stall is low.
//     req_type update trains the entry at pc and gives no result.
//     req_type predict gives one result beat on the output channel.
//   Output channel (out_valid / out_stall): predicted_addr, packet_size_out,
//     prediction_made. predicted_addr is 0 unless prediction_made is set.
//   Config channel (cfg_valid / cfg_ready): cfg_ready is always high; write
//     only while the block is idle. Indexes past the last register are dropped.
//   Throughput: one beat per cycle while in_stall is low, predict or update, in any mix.
//   Pipeline: a predict's result is held in the result register of stage 3.
//     Stage 1 reads the table memory, stage 2 does the update (written back
//     at its end) or the multiply, stage 3 is the add into the result register.
//     Back-to-back updates to one slot go through a write bypass in the table.
//   Stall: out_stall holds the result; the pipeline keeps taking beats until
//     a predict can no longer move forward, then in_stall rises.
//   Reset: config registers take their defaults, every entry becomes empty.
// ----------------------------------------------------------------------------
module stride_address_predictor (
    input  logic                          clk,
    input  logic                          rst_n,
    // request channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          req_type,
    input  logic [sap_pkg::ADDR_W-1:0]    pc,
    input  logic [sap_pkg::ADDR_W-1:0]    real_addr,
    input  logic [sap_pkg::AHEAD_W-1:0]   run_ahead,
    input  logic [sap_pkg::SIZE_W-1:0]    access_size,
    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [sap_pkg::ADDR_W-1:0]    predicted_addr,
    output logic [sap_pkg::SIZE_W-1:0]    packet_size_out,
    output logic                          prediction_made,
    // config channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sap_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sap_pkg::CONF_W-1:0]    cfg_data
);
    import sap_pkg::*;

    cfg_t   cfg;
    logic   accept;
    idx_t   in_idx;

    // stage 2 request register
    logic   s2_valid_reg;
    logic   s2_req_reg;
    addr_t  s2_pc_reg;
    addr_t  s2_addr_reg;
    logic [AHEAD_W-1:0] s2_ahead_reg;
    size_t  s2_size_reg;
    idx_t   s2_idx_reg;

    logic   s2_is_pred;
    logic   s2_move;
    logic   pred_ready;
    logic   wr_en;

    logic   tbl_entry_valid;
    logic   tbl_stride_valid;
    entry_t tbl_entry;
    entry_t learn_entry;
    logic   learn_stride_valid;

    assign cfg_ready = 1'b1;

    sap_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Pipeline control: updates always retire in stage 2, a predict moves on
    // only when the product stage has room.
    assign s2_is_pred = s2_valid_reg && (s2_req_reg == REQ_PREDICT);
    assign s2_move    = !s2_is_pred || pred_ready;
    assign in_stall   = !s2_move;
    assign accept     = in_valid && !in_stall;
    assign in_idx     = slot_of(pc);
    assign wr_en      = s2_valid_reg && (s2_req_reg == REQ_UPDATE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_move)
        begin
            s2_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s2_req_reg   <= req_type;
            s2_pc_reg    <= pc;
            s2_addr_reg  <= real_addr;
            s2_ahead_reg <= run_ahead;
            s2_size_reg  <= access_size;
            s2_idx_reg   <= in_idx;
        end
    end

    sap_table u_table (
        .clk             (clk),
        .rst_n           (rst_n),
        .rd_en           (accept),
        .rd_idx          (in_idx),
        .look_idx        (s2_idx_reg),
        .wr_en           (wr_en),
        .wr_idx          (s2_idx_reg),
        .wr_entry        (learn_entry),
        .wr_stride_valid (learn_stride_valid),
        .entry_valid     (tbl_entry_valid),
        .stride_valid    (tbl_stride_valid),
        .entry           (tbl_entry)
    );

    sap_learn u_learn (
        .entry_valid      (tbl_entry_valid),
        .stride_valid     (tbl_stride_valid),
        .cur              (tbl_entry),
        .pc               (s2_pc_reg),
        .real_addr        (s2_addr_reg),
        .access_size      (s2_size_reg),
        .cfg              (cfg),
        .nxt              (learn_entry),
        .nxt_stride_valid (learn_stride_valid)
    );

    // predict ignores the tag: the indexed entry answers as it stands
    sap_predict u_predict (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (s2_is_pred),
        .req_ready       (pred_ready),
        .entry_valid     (tbl_entry_valid),
        .stride_valid    (tbl_stride_valid),
        .entry           (tbl_entry),
        .run_ahead       (s2_ahead_reg),
        .threshold       (cfg.threshold),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .predicted_addr  (predicted_addr),
        .packet_size_out (packet_size_out),
        .prediction_made (prediction_made)
    );

endmodule

// ===== src/sap_checker.sv =====
// ----------------------------------------------------------------------------
// sap_checker - port-level assertions for the stride address predictor
// Watches the channels over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module sap_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_stall,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic [sap_pkg::ADDR_W-1:0] predicted_addr,
    input logic [sap_pkg::SIZE_W-1:0] packet_size_out,
    input logic                       prediction_made,
    input logic                       cfg_valid,
    input logic                       cfg_ready
);

    // a stalled result beat stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(predicted_addr)
            && $stable(packet_size_out) && $stable(prediction_made))
        else $error("stalled result beat changed");

    // backpressure only ever comes from a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("request stalled without a stalled result");

    a_no_pred_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !prediction_made |-> predicted_addr == '0)
        else $error("address given without a prediction");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write refused");

endmodule

bind stride_address_predictor sap_checker u_sap_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .predicted_addr  (predicted_addr),
    .packet_size_out (packet_size_out),
    .prediction_made (prediction_made),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready)
);
